@@ hw/rtl/utf8s_pkg.sv @@
package utf8s_pkg;

	localparam int unsigned MaxBytes = 6;

	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	localparam logic [20:0] MIN_CP2 = 21'h00080;
	localparam logic [20:0] MIN_CP3 = 21'h00800;
	localparam logic [20:0] MIN_CP4 = 21'h10000;
	localparam logic [20:0] MAX_CP = 21'h10FFFF;
	localparam logic [20:0] SURR_LO = 21'h0D800;
	localparam logic [20:0] SURR_HI = 21'h0DFFF;

	typedef enum logic [2:0] {
		LEAD_ASCII,
		LEAD_TWO,
		LEAD_THREE,
		LEAD_FOUR,
		LEAD_BAD
	} lead_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       message_done;
	} result_t;

	// All result bytes caused by one input item.
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [2:0]               count;
		logic                     done;
	} run_t;

endpackage

@@ hw/rtl/utf8s_front.sv @@
module utf8s_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  utf8s_pkg::item_t item,
	input  logic             q_full,
	output logic             push,
	output utf8s_pkg::run_t  run
);
	import utf8s_pkg::*;

	logic [2:0][7:0] held_bytes_q, held_bytes_d;
	logic [1:0]      held_count_q, held_count_d;
	logic [1:0]      need_q, need_d;
	logic [20:0]     partial_q, partial_d;

	logic [7:0]  b;
	logic        accept;
	lead_t       lcls;
	logic [20:0] cp;
	logic [20:0] cp_min;
	logic        cp_bad;
	logic [2:0]  base;

	assign b          = item.data_byte;
	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign push       = accept && (run.count != 3'd0);

	always_comb begin
		if (!b[7]) begin
			lcls = LEAD_ASCII;
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			lcls = LEAD_TWO;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			lcls = LEAD_THREE;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			lcls = LEAD_FOUR;
		end else begin
			lcls = LEAD_BAD;
		end
	end

	assign cp = {partial_q[14:0], b[5:0]};

	always_comb begin
		if (held_bytes_q[0] <= LEAD2_HI) begin
			cp_min = MIN_CP2;
		end else if (held_bytes_q[0] <= LEAD3_HI) begin
			cp_min = MIN_CP3;
		end else begin
			cp_min = MIN_CP4;
		end
	end

	assign cp_bad = (cp < cp_min) || (cp > MAX_CP) || (cp >= SURR_LO && cp <= SURR_HI);

	always_comb begin
		held_bytes_d = held_bytes_q;
		held_count_d = held_count_q;
		need_d       = need_q;
		partial_d    = partial_q;
		run          = '0;
		base         = 3'd0;
		if (item.message_end) begin
			if (held_count_q != 2'd0) begin
				run.bytes[0] = REPL_B0;
				run.bytes[1] = REPL_B1;
				run.bytes[2] = REPL_B2;
				run.count    = 3'd4;
			end else begin
				run.count = 3'd1;
			end
			run.done     = 1'b1;
			held_bytes_d = '0;
			held_count_d = 2'd0;
			need_d       = 2'd0;
			partial_d    = '0;
		end else if (held_count_q != 2'd0 && b[7:6] == 2'b10) begin
			if (need_q > 2'd1) begin
				held_bytes_d[held_count_q] = b;
				held_count_d               = held_count_q + 2'd1;
				need_d                     = need_q - 2'd1;
				partial_d                  = cp;
			end else begin
				if (cp_bad) begin
					run.bytes[0] = REPL_B0;
					run.bytes[1] = REPL_B1;
					run.bytes[2] = REPL_B2;
					run.count    = 3'd3;
				end else begin
					run.bytes[0]            = held_bytes_q[0];
					run.bytes[1]            = held_bytes_q[1];
					run.bytes[2]            = held_bytes_q[2];
					run.bytes[held_count_q] = b;
					run.count               = {1'b0, held_count_q} + 3'd1;
				end
				held_bytes_d = '0;
				held_count_d = 2'd0;
				need_d       = 2'd0;
				partial_d    = '0;
			end
		end else begin
			if (held_count_q != 2'd0) begin
				run.bytes[0] = REPL_B0;
				run.bytes[1] = REPL_B1;
				run.bytes[2] = REPL_B2;
				base         = 3'd3;
			end
			held_bytes_d = '0;
			held_count_d = 2'd0;
			need_d       = 2'd0;
			partial_d    = '0;
			case (lcls)
				LEAD_ASCII: begin
					run.bytes[base] = b;
					run.count       = base + 3'd1;
				end
				LEAD_TWO: begin
					run.count       = base;
					held_bytes_d[0] = b;
					held_count_d    = 2'd1;
					need_d          = 2'd1;
					partial_d       = {16'd0, b[4:0]};
				end
				LEAD_THREE: begin
					run.count       = base;
					held_bytes_d[0] = b;
					held_count_d    = 2'd1;
					need_d          = 2'd2;
					partial_d       = {17'd0, b[3:0]};
				end
				LEAD_FOUR: begin
					run.count       = base;
					held_bytes_d[0] = b;
					held_count_d    = 2'd1;
					need_d          = 2'd3;
					partial_d       = {18'd0, b[2:0]};
				end
				default: begin
					run.bytes[base]        = REPL_B0;
					run.bytes[base + 3'd1] = REPL_B1;
					run.bytes[base + 3'd2] = REPL_B2;
					run.count              = base + 3'd3;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bytes_q <= '0;
			held_count_q <= 2'd0;
			need_q       <= 2'd0;
			partial_q    <= '0;
		end else if (accept) begin
			held_bytes_q <= held_bytes_d;
			held_count_q <= held_count_d;
			need_q       <= need_d;
			partial_q    <= partial_d;
		end
	end

endmodule

@@ hw/rtl/utf8s_queue.sv @@
module utf8s_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  utf8s_pkg::run_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output utf8s_pkg::run_t pop_data
);
	import utf8s_pkg::*;

	run_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign pop_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

@@ hw/rtl/utf8s_back.sv @@
module utf8s_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  utf8s_pkg::run_t    q_data,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output utf8s_pkg::result_t result
);
	import utf8s_pkg::*;

	run_t       cur_q;
	logic       cur_valid_q;
	logic [2:0] idx_q;
	logic       last;
	logic       take;

	assign last = (idx_q + 3'd1 == cur_q.count);
	assign take = !cur_valid_q || (!result_stall && last);
	assign pop  = take && q_not_empty;

	assign result_valid        = cur_valid_q;
	assign result.out_byte     = cur_q.bytes[idx_q];
	assign result.run_last     = last;
	assign result.message_done = cur_q.done && last;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else if (take) begin
			cur_valid_q <= q_not_empty;
			idx_q       <= 3'd0;
		end else if (!result_stall) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

@@ hw/rtl/utf8_sanitizer.sv @@
// Streaming UTF-8 sanitizer. Each input beat carries one message byte or an end-of-message
// marker; well-formed UTF-8 leaves unchanged, malformed pieces leave as EF BF BD, and every
// message closes with one beat of byte 00 flagged message_done. One input beat can cause zero
// to six output beats, and run_last flags the last of them. Input is taken once per cycle
// while the two-entry queue between the decoder and the serializer has room, and the output
// port delivers one byte per cycle while result_stall is low, so the output port sets the
// sustained rate: with the queue full, an N-byte run holds input back while it is sent.
module utf8_sanitizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  utf8s_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output utf8s_pkg::result_t result
);
	import utf8s_pkg::*;

	run_t run_push;
	run_t run_pop;
	logic push;
	logic pop;
	logic q_full;
	logic q_not_empty;

	utf8s_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_full     (q_full),
		.push       (push),
		.run        (run_push)
	);

	utf8s_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (run_push),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_data  (run_pop)
	);

	utf8s_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_data       (run_pop),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_no_push_when_full : assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	a_done_is_last_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.message_done) |-> (result.run_last && result.out_byte == 8'h00))
		else $error("closing beat malformed");

	a_end_item_pushes : assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.message_end) |-> (push && run_push.done))
		else $error("end of message produced no closing run");

endmodule
